// ===== rtl/packed_raw_pixel_unpacker_top_macros.svh =====
// assertion macros shared by the packed raw pixel unpacker rtl
`ifndef PACKED_RAW_PIXEL_UNPACKER_TOP_MACROS_SVH
`define PACKED_RAW_PIXEL_UNPACKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PPU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppu assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PPU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppu assertion failed");

`endif

// ===== rtl/ppu_pkg.sv =====
// shared types and constants of the packed raw pixel unpacker
`timescale 1ns / 1ps

package ppu_pkg;

    localparam int WORD_W           = 16;
    localparam int PIX_W            = 16;
    localparam int DEPTH_W          = 5;
    localparam int CFG_DIM_W        = 14;
    localparam int CFG_DATA_W       = 14;
    localparam int CFG_IDX_W        = 2;
    localparam int ACC_W            = 31;
    localparam int HELD_W           = 5;
    localparam int NPIX_W           = 4;
    localparam int MAX_PIX_PER_WORD = 16;
    localparam int MAX_PIX_DEPTH    = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int DEFAULT_MAX_DIMENSION = 8192;

    localparam logic [DEPTH_W-1:0]   RESET_BIT_DEPTH    = 5'd14;
    localparam logic [CFG_DIM_W-1:0] RESET_IMAGE_WIDTH  = 14'd1920;
    localparam logic [CFG_DIM_W-1:0] RESET_IMAGE_HEIGHT = 14'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_DEPTH    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } queue_head_t;

endpackage

// ===== rtl/ppu_front.sv =====
// input side: accepts packed words into a short queue ahead of the unpack engine
`timescale 1ns / 1ps

module ppu_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ppu_pkg::WORD_W-1:0]  packed_word,
    output ppu_pkg::queue_head_t        head,
    input  logic                        pop
);
    import ppu_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WORD_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push;

    assign in_stall   = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head.valid = (fill_reg != '0);
    assign head.word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= packed_word;
        end
    end

endmodule

// ===== rtl/ppu_back.sv =====
// unpack engine: bit accumulator, pixel counter and output register
`timescale 1ns / 1ps

module ppu_back #(
    parameter int CNT_W = 28
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppu_pkg::queue_head_t         head,
    output logic                         pop,
    input  logic [ppu_pkg::DEPTH_W-1:0]  bd,
    input  logic [CNT_W-1:0]             total,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ppu_pkg::PIX_W-1:0]    pixel_value,
    output logic                         last_of_word,
    output logic                         last_of_frame
);
    import ppu_pkg::*;

    `include "packed_raw_pixel_unpacker_top_macros.svh"

    logic              active_reg, active_next, active_base;
    logic [ACC_W-1:0]  acc_reg, acc_next, acc_base;
    logic [HELD_W-1:0] held_reg, held_next, held_base;
    logic [NPIX_W-1:0] npix_reg, npix_next;
    logic [CNT_W-1:0]  count_reg, count_next, count_inc;

    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  pixel_reg;
    logic              last_word_reg;
    logic              last_frame_reg;

    logic              emit;
    logic [HELD_W-1:0] rem;
    logic [ACC_W-1:0]  shifted;
    logic [ACC_W-1:0]  keep_mask;
    logic [PIX_W-1:0]  pix_mask;
    logic [PIX_W-1:0]  pixel;
    logic              frame_end;
    logic              last_word;

    assign emit      = active_reg && (!out_valid_reg || !out_stall);
    assign rem       = held_reg - bd;
    assign shifted   = acc_reg >> rem;
    assign pix_mask  = PIX_W'((32'd1 << bd) - 32'd1);
    assign pixel     = shifted[PIX_W-1:0] & pix_mask;
    assign keep_mask = ACC_W'((32'd1 << rem) - 32'd1);
    assign count_inc = count_reg + CNT_W'(1);
    assign frame_end = (count_inc >= total);
    assign last_word = frame_end || (npix_reg == NPIX_W'(MAX_PIX_PER_WORD - 1))
                       || (rem < bd);

    always_comb
    begin
        acc_base    = acc_reg;
        held_base   = held_reg;
        count_next  = count_reg;
        npix_next   = npix_reg;
        active_base = active_reg;
        if (emit)
        begin
            if (frame_end)
            begin
                // leftover padding bits are dropped at frame end
                acc_base   = '0;
                held_base  = '0;
                count_next = '0;
            end
            else
            begin
                acc_base   = acc_reg & keep_mask;
                held_base  = rem;
                count_next = count_inc;
            end
            npix_next = npix_reg + 1'b1;
            if (last_word)
            begin
                active_base = 1'b0;
            end
        end

        pop         = head.valid && !active_base;
        acc_next    = acc_base;
        held_next   = held_base;
        active_next = active_base;
        if (pop)
        begin
            acc_next    = {acc_base[ACC_W-WORD_W-1:0], head.word};
            held_next   = held_base + HELD_W'(WORD_W);
            npix_next   = '0;
            active_next = 1'b1;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            acc_reg       <= '0;
            held_reg      <= '0;
            npix_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            npix_reg      <= npix_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_reg      <= pixel;
            last_word_reg  <= last_word;
            last_frame_reg <= frame_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_value   = pixel_reg;
    assign last_of_word  = last_word_reg;
    assign last_of_frame = last_frame_reg;

    `PPU_ASSERT_NOW(a_active_has_pixel, active_reg, held_reg >= bd)
    `PPU_ASSERT_NOW(a_idle_held_narrow, !active_reg, held_reg < HELD_W'(WORD_W))
    `PPU_ASSERT_NEXT(a_frame_end_clears, emit && frame_end, count_reg == '0)
    `PPU_ASSERT_NOW(a_frame_ends_word, out_valid_reg && last_frame_reg, last_word_reg)

endmodule

// ===== rtl/packed_raw_pixel_unpacker_top.sv =====
// Packed raw pixel unpacker. Takes 16-bit words of a raw frame and unpacks
// pixels of bit_depth bits, packed msb first across word boundaries, each
// zero-extended to 16 bits; last_of_word marks the final pixel of a word and
// last_of_frame the pixel that completes image_width * image_height, after
// which leftover bits are dropped. Every word yields between 1 and 16 pixels.
// Words wait in a two-entry queue; the unpack engine emits one pixel per cycle
// unless out_stall holds its output, and loads the next word in the same cycle
// as the last pixel of the current one; a word yields one or two pixels at 10
// to 16 bit depths. The first pixel of a word passes the queue, the accumulator
// and the output register. A new bit depth applies from the cycle after its
// write, a new frame size after the size and total registers; configuration
// writes must be made while no transaction is in flight.
`timescale 1ns / 1ps

module packed_raw_pixel_unpacker_top #(
    parameter int MAX_DIMENSION = ppu_pkg::DEFAULT_MAX_DIMENSION
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ppu_pkg::WORD_W-1:0]     packed_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ppu_pkg::PIX_W-1:0]      pixel_value,
    output logic                           last_of_word,
    output logic                           last_of_frame
);
    import ppu_pkg::*;

    localparam int CFG_DIM_MAX = 2 ** CFG_DIM_W - 1;
    localparam int EFF_MAX     = (MAX_DIMENSION < CFG_DIM_MAX) ? MAX_DIMENSION : CFG_DIM_MAX;
    localparam int DIM_W       = $clog2(EFF_MAX + 1);
    localparam int CNT_W       = 2 * DIM_W;

    logic [DEPTH_W-1:0]   bit_depth_reg;
    logic [CFG_DIM_W-1:0] image_width_reg;
    logic [CFG_DIM_W-1:0] image_height_reg;
    logic [DEPTH_W-1:0]   bd;
    logic [DIM_W-1:0]     width_clamp;
    logic [DIM_W-1:0]     height_clamp;
    logic [CNT_W-1:0]     total_next;
    logic [CNT_W-1:0]     total_reg;
    queue_head_t          head;
    logic                 pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg    <= RESET_BIT_DEPTH;
            image_width_reg  <= RESET_IMAGE_WIDTH;
            image_height_reg <= RESET_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_DEPTH:    bit_depth_reg    <= cfg_data[DEPTH_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[CFG_DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp settings into their legal ranges
    always_comb
    begin
        if (bit_depth_reg == '0)
        begin
            bd = DEPTH_W'(1);
        end
        else if (bit_depth_reg > DEPTH_W'(MAX_PIX_DEPTH))
        begin
            bd = DEPTH_W'(MAX_PIX_DEPTH);
        end
        else
        begin
            bd = bit_depth_reg;
        end

        if (image_width_reg == '0)
        begin
            width_clamp = DIM_W'(1);
        end
        else if (32'(image_width_reg) > 32'(EFF_MAX))
        begin
            width_clamp = DIM_W'(EFF_MAX);
        end
        else
        begin
            width_clamp = DIM_W'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            height_clamp = DIM_W'(1);
        end
        else if (32'(image_height_reg) > 32'(EFF_MAX))
        begin
            height_clamp = DIM_W'(EFF_MAX);
        end
        else
        begin
            height_clamp = DIM_W'(image_height_reg);
        end

        total_next = CNT_W'(width_clamp) * CNT_W'(height_clamp);
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
    end

    ppu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .packed_word (packed_word),
        .head        (head),
        .pop         (pop)
    );

    ppu_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .bd            (bd),
        .total         (total_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_value   (pixel_value),
        .last_of_word  (last_of_word),
        .last_of_frame (last_of_frame)
    );

endmodule
